/* hdl/rims_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rims_pkg
// Shared types, constants and the item ordering function of the sorter.
// ----------------------------------------------------------------------------
package rims_pkg;

  localparam int MaxItems = 64;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);
  localparam int ZkeyW    = 40;

  localparam logic [1:0] ModeFlat = 2'd0;
  localparam logic [1:0] Mode3d   = 2'd1;
  localparam logic [1:0] ModeClip = 2'd2;

  localparam logic CfgCompareMode = 1'b0;
  localparam logic CfgZMode       = 1'b1;

  typedef struct packed {
    logic [47:0]              id;
    logic                     opaque;
    logic [15:0]              clip;
    logic signed [15:0]       depth;
    logic [15:0]              tag;
    logic signed [ZkeyW-1:0]  zkey;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQUARE, ST_WRITE, ST_SCAN_INIT, ST_SCAN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic write;
    logic scan_start;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_item;
    logic scan_done;
    logic out_free;
    logic final_pos;
  } sts_t;

  function automatic logic item_less(logic [1:0] mode, entry_t a, entry_t b);
    logic pl;
    logic l3;
    logic res;
    pl = a.id < b.id;
    if (a.opaque != b.opaque) begin
      l3 = a.opaque;
    end else if (a.opaque) begin
      l3 = pl;
    end else if (a.depth != b.depth) begin
      l3 = $signed(a.depth) < $signed(b.depth);
    end else if (a.zkey == b.zkey) begin
      l3 = pl;
    end else begin
      l3 = $signed(a.zkey) > $signed(b.zkey);
    end
    if (mode == ModeFlat) begin
      res = (a.depth != b.depth) ? ($signed(a.depth) < $signed(b.depth)) : pl;
    end else if (mode == Mode3d) begin
      res = l3;
    end else begin
      res = (a.clip != b.clip) ? (a.clip < b.clip) : l3;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/render_item_multikey_stable_sort.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// render_item_multikey_stable_sort
// Collects draw items and returns their tags in stable multi-key order.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall  item fields, last flag
//   out_     out        out_valid/out_stall sorted tag, last flag
//   cfg_     in         cfg_valid/cfg_ready register index, data
//
// Loading an item steps through capture, squares, then sum and store write.
// After the last item, each result takes one scan of the n stored entries
// through the single read port.
// Synchronous active-low reset empties the list; stored entries are kept.
// A stalled result holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module render_item_multikey_stable_sort (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_item_tag,
  input  wire logic signed [15:0] in_depth_index,
  input  wire logic [15:0]        in_shader_id,
  input  wire logic [15:0]        in_texture_set_id,
  input  wire logic [15:0]        in_geometry_id,
  input  wire logic               in_is_opaque,
  input  wire logic [15:0]        in_clip_order,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [15:0] in_pos_z,
  input  wire logic               in_last_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_sorted_tag,
  output logic                    out_last_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [1:0]         cfg_data
);
  import rims_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rims_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rims_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_item_tag       (in_item_tag),
    .in_depth_index    (in_depth_index),
    .in_shader_id      (in_shader_id),
    .in_texture_set_id (in_texture_set_id),
    .in_geometry_id    (in_geometry_id),
    .in_is_opaque      (in_is_opaque),
    .in_clip_order     (in_clip_order),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_tag    (out_sorted_tag),
    .out_last_out      (out_last_out)
  );

endmodule
`default_nettype wire

/* hdl/rims_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rims_ctrl
// Sequencer: load, key computation, selection scans and result emission.
// ----------------------------------------------------------------------------
module rims_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rims_pkg::sts_t  sts,
  output rims_pkg::cmd_t       cmd
);
  import rims_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = sts.last_item ? ST_SCAN_INIT : ST_IDLE;
      end
      ST_SCAN_INIT: begin
        cmd.scan_start = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.final_pos ? ST_IDLE : ST_SCAN_INIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/rims_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rims_dp
// Item store, z key arithmetic, minimum scan and output register.
// ----------------------------------------------------------------------------
module rims_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rims_pkg::cmd_t     cmd,
  output rims_pkg::sts_t          sts,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_index,
  input  wire logic [1:0]         cfg_data,
  input  wire logic [15:0]        in_item_tag,
  input  wire logic signed [15:0] in_depth_index,
  input  wire logic [15:0]        in_shader_id,
  input  wire logic [15:0]        in_texture_set_id,
  input  wire logic [15:0]        in_geometry_id,
  input  wire logic               in_is_opaque,
  input  wire logic [15:0]        in_clip_order,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [15:0] in_pos_z,
  input  wire logic               in_last_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_sorted_tag,
  output logic                    out_last_out
);
  import rims_pkg::*;

  logic [1:0]              compare_mode_r;
  logic                    z_mode_r;
  entry_t                  cap_r;
  logic                    cap_zmode_r;
  logic                    cap_last_r;
  logic signed [15:0]      px_r, py_r, pz_r;
  logic signed [31:0]      sqx_r, sqy_r, sqz_r;
  logic signed [ZkeyW-1:0] zkey;
  entry_t                  wr_entry;
  entry_t                  mem [MaxItems];
  entry_t                  rd_data_r;
  logic [IdxW-1:0]         rd_idx_r;
  logic                    rdv_r;
  logic [CntW-1:0]         count_r;
  logic [CntW-1:0]         addr_r;
  logic [CntW-1:0]         pos_r;
  logic [MaxItems-1:0]     emitted_r;
  entry_t                  best_r;
  logic [IdxW-1:0]         best_idx_r;
  logic                    best_valid_r;
  logic                    take;
  logic                    out_valid_r;
  logic [15:0]             out_tag_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_mode_r <= '0;
      z_mode_r       <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgCompareMode) compare_mode_r <= cfg_data;
      else z_mode_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_r.id     <= {in_shader_id, in_texture_set_id, in_geometry_id};
      cap_r.opaque <= in_is_opaque;
      cap_r.clip   <= in_clip_order;
      cap_r.depth  <= in_depth_index;
      cap_r.tag    <= in_item_tag;
      cap_r.zkey   <= '0;
      cap_zmode_r  <= z_mode_r;
      cap_last_r   <= in_last_item;
      px_r         <= in_pos_x;
      py_r         <= in_pos_y;
      pz_r         <= in_pos_z;
    end
    if (cmd.square) begin
      sqx_r <= px_r * px_r;
      sqy_r <= py_r * py_r;
      sqz_r <= pz_r * pz_r;
    end
  end

  always_comb begin
    if (cap_zmode_r) begin
      zkey = ZkeyW'(sqx_r) + ZkeyW'(sqy_r) + ZkeyW'(sqz_r);
    end else begin
      zkey = {{(ZkeyW-24){pz_r[15]}}, pz_r, 8'd0};
    end
    zkey = zkey - {{(ZkeyW-32){cap_r.depth[15]}}, cap_r.depth, 16'd0};
    wr_entry      = cap_r;
    wr_entry.zkey = zkey;
  end

  always_ff @(posedge clk) begin
    if (cmd.write && count_r < CntW'(MaxItems)) mem[count_r[IdxW-1:0]] <= wr_entry;
    if (cmd.scan && addr_r < count_r) rd_data_r <= mem[addr_r[IdxW-1:0]];
  end

  assign take = rdv_r && !emitted_r[rd_idx_r] &&
                (!best_valid_r || item_less(compare_mode_r, rd_data_r, best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      addr_r       <= '0;
      pos_r        <= '0;
      emitted_r    <= '0;
      rdv_r        <= 1'b0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.write && count_r < CntW'(MaxItems)) count_r <= count_r + 1'b1;
      if (cmd.scan_start) begin
        addr_r       <= '0;
        rdv_r        <= 1'b0;
        best_valid_r <= 1'b0;
      end
      if (cmd.scan) begin
        rdv_r <= addr_r < count_r;
        if (addr_r < count_r) begin
          rd_idx_r <= addr_r[IdxW-1:0];
          addr_r   <= addr_r + 1'b1;
        end
        if (take) begin
          best_r       <= rd_data_r;
          best_idx_r   <= rd_idx_r;
          best_valid_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_tag_r   <= best_r.tag;
        out_last_r  <= sts.final_pos;
        if (sts.final_pos) begin
          pos_r     <= '0;
          count_r   <= '0;
          emitted_r <= '0;
        end else begin
          pos_r                 <= pos_r + 1'b1;
          emitted_r[best_idx_r] <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.last_item = cap_last_r;
    sts.scan_done = rdv_r && ({1'b0, rd_idx_r} + 1'b1 == count_r);
    sts.out_free  = !out_valid_r || !out_stall;
    sts.final_pos = pos_r + 1'b1 == count_r;
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_tag = out_tag_r;
  assign out_last_out   = out_last_r;

endmodule
`default_nettype wire

/* test/render_item_multikey_stable_sort_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// render_item_multikey_stable_sort_test
// Drives draw item lists through the sorter and checks every sorted tag and
// its last flag against an in-bench stable multi-key sort of the same items.
// ----------------------------------------------------------------------------
module render_item_multikey_stable_sort_test;
  import rims_pkg::*;

  localparam int Cap       = 64;
  localparam int IdleLimit = 20000;
  localparam int HoldLen   = 400;

  typedef struct {
    logic [15:0] tag;
    logic [15:0] depth;
    logic [15:0] shader;
    logic [15:0] texset;
    logic [15:0] geom;
    logic        opaque;
    logic [15:0] clip;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic        last;
  } draw_item_t;

  typedef struct {
    logic [15:0]        tag;
    logic signed [15:0] depth;
    logic [47:0]        id;
    logic               opaque;
    logic [15:0]        clip;
    logic signed [39:0] zkey;
  } stored_item_t;

  typedef struct {
    logic [15:0] tag;
    logic        last;
  } sorted_tag_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  draw_item_t cur = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_sorted_tag;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_data = 2'd0;

  stored_item_t loaded_items[$];
  sorted_tag_t sorted_tags_due[$];
  logic [1:0] order_mode = ModeFlat;
  logic zsq_mode = 1'b0;
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  render_item_multikey_stable_sort dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_item_tag(cur.tag), .in_depth_index(cur.depth), .in_shader_id(cur.shader),
    .in_texture_set_id(cur.texset), .in_geometry_id(cur.geom),
    .in_is_opaque(cur.opaque), .in_clip_order(cur.clip),
    .in_pos_x(cur.px), .in_pos_y(cur.py), .in_pos_z(cur.pz),
    .in_last_item(cur.last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sorted_tag(out_sorted_tag), .out_last_out(out_last_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit trans_less(stored_item_t a, stored_item_t b);
    if (a.opaque != b.opaque) return a.opaque;
    if (a.opaque) return a.id < b.id;
    if (a.depth != b.depth) return a.depth < b.depth;
    if (a.zkey == b.zkey) return a.id < b.id;
    return a.zkey > b.zkey;
  endfunction

  function automatic bit draws_first(logic [1:0] mode, stored_item_t a, stored_item_t b);
    if (mode == ModeFlat) begin
      if (a.depth != b.depth) return a.depth < b.depth;
      return a.id < b.id;
    end
    if (mode == Mode3d) return trans_less(a, b);
    if (a.clip != b.clip) return a.clip < b.clip;
    return trans_less(a, b);
  endfunction

  task automatic load_and_sort(draw_item_t it);
    stored_item_t s;
    longint z;
    longint x;
    longint y;
    longint w;
    int order[$];
    int j;
    sorted_tag_t r;
    if (loaded_items.size() < Cap) begin
      x = longint'($signed(it.px));
      y = longint'($signed(it.py));
      w = longint'($signed(it.pz));
      z = zsq_mode ? x * x + y * y + w * w : w * 256;
      z -= longint'($signed(it.depth)) * 65536;
      s.tag = it.tag;
      s.depth = it.depth;
      s.id = {it.shader, it.texset, it.geom};
      s.opaque = it.opaque;
      s.clip = it.clip;
      s.zkey = z[39:0];
      loaded_items.push_back(s);
    end
    if (it.last) begin
      for (int i = 0; i < loaded_items.size(); i++) begin
        j = order.size();
        while (j > 0 && draws_first(order_mode, loaded_items[i], loaded_items[order[j-1]]))
          j--;
        order.insert(j, i);
      end
      foreach (order[k]) begin
        r.tag = loaded_items[order[k]].tag;
        r.last = (k == order.size() - 1);
        sorted_tags_due.push_back(r);
      end
      loaded_items.delete();
    end
  endtask

  task automatic send_item(draw_item_t it);
    if (!quiet && $urandom_range(0, 99) < 36) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cur = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    load_and_sort(it);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgCompareMode) order_mode = (val == 2'd3) ? ModeClip : val;
    else zsq_mode = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    while (sorted_tags_due.size() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [15:0] pick16(bit tie);
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return tie ? 16'($urandom_range(0, 3)) : 16'($urandom);
    endcase
  endfunction

  function automatic draw_item_t rand_item(bit tie, bit last);
    draw_item_t it;
    it.tag = 16'($urandom);
    it.depth = pick16(tie);
    it.shader = pick16(tie);
    it.texset = pick16(tie);
    it.geom = pick16(tie);
    it.opaque = 1'($urandom_range(0, 1));
    it.clip = pick16(tie);
    it.px = pick16(tie);
    it.py = pick16(tie);
    it.pz = pick16(tie);
    it.last = last;
    return it;
  endfunction

  task automatic send_list(int n, bit tie);
    for (int i = 0; i < n; i++) send_item(rand_item(tie, i == n - 1));
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    sorted_tag_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_tags_due.size() == 0) begin
        report_mismatch("unexpected transfer", out_sorted_tag, 16'h0);
      end else begin
        e = sorted_tags_due.pop_front();
        if (out_sorted_tag !== e.tag) report_mismatch("sorted_tag", out_sorted_tag, e.tag);
        if (out_last_out !== e.last)
          report_mismatch("last_out", 16'(out_last_out), 16'(e.last));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldLen;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 36);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_extremes;
    draw_item_t it;
    write_reg(CfgCompareMode, ModeFlat);
    write_reg(CfgZMode, 2'd0);
    it = '{default: '0};
    send_item(it);
    it = '{tag: 16'hFFFF, depth: 16'h7FFF, shader: 16'hFFFF, texset: 16'hFFFF,
           geom: 16'hFFFF, opaque: 1'b1, clip: 16'hFFFF, px: 16'h7FFF,
           py: 16'h7FFF, pz: 16'h7FFF, last: 1'b0};
    send_item(it);
    it.depth = 16'h8000; it.px = 16'h8000; it.py = 16'h8000; it.pz = 16'h8000;
    it.tag = 16'h8000; it.opaque = 1'b0;
    send_item(it);
    it.tag = 16'h0001;
    send_item(it);
    send_item(rand_item(1'b0, 1'b1));
    drain();
  endtask

  task automatic test_modes;
    write_reg(CfgZMode, 2'd1);
    for (int m = 1; m <= 3; m++) begin
      write_reg(CfgCompareMode, 2'(m));
      send_list(4, 1'b1);
      drain();
    end
  endtask

  task automatic test_zmode_mid_list;
    write_reg(CfgCompareMode, Mode3d);
    write_reg(CfgZMode, 2'd0);
    send_list(2, 1'b1);
    for (int i = 0; i < 2; i++) send_item(rand_item(1'b1, 1'b0));
    drain();
    write_reg(CfgZMode, 2'd1);
    send_list(3, 1'b1);
    drain();
  endtask

  task automatic test_full_list;
    write_reg(CfgCompareMode, ModeClip);
    for (int i = 0; i < Cap; i++) send_item(rand_item(1'b1, 1'b0));
    send_item(rand_item(1'b0, 1'b0));
    send_item(rand_item(1'b0, 1'b1));
    drain();
    send_list(1, 1'b0);
    drain();
  endtask

  task automatic test_back_pressure;
    write_reg(CfgCompareMode, ModeFlat);
    send_list(10, 1'b1);
    hold_req = 1'b1;
    send_list(10, 1'b1);
    drain();
  endtask

  task automatic test_random_lists;
    int n;
    int lists;
    int r;
    lists = 0;
    while (items_sent < 350) begin
      r = $urandom_range(0, 99);
      n = (r < 80) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 20)
                                                     : $urandom_range(40, Cap);
      quiet = (lists >= 10 && lists < 20);
      send_list(n, $urandom_range(0, 1));
      lists++;
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(CfgCompareMode, 2'($urandom_range(0, 3)));
        write_reg(CfgZMode, 2'($urandom_range(0, 1)));
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_modes();
    test_zmode_mid_list();
    test_full_list();
    test_back_pressure();
    test_random_lists();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && sorted_tags_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
